[rtl/sdcsd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD CSD decoder package
// Shared beat types, decode tables and structure codes for the CSD decoder.
// ----------------------------------------------------------------------------
package sdcsd_pkg;

	// CSD_STRUCTURE codes.
	localparam logic [1:0] STRUCT_V1    = 2'd0;
	localparam logic [1:0] STRUCT_V2    = 2'd1;
	localparam logic [1:0] STRUCT_RSVD2 = 2'd2;
	localparam logic [1:0] STRUCT_RSVD3 = 2'd3;

	// Fixed values that a version 2 card reports.
	localparam logic [7:0] V2_BLOCK_LEN = 8'h99;
	localparam logic [7:0] V2_ATTR      = 8'h80;
	localparam logic [4:0] V2_CAP_SHIFT = 5'd10;

	// Input beat: one raw 128-bit response without the CRC byte.
	typedef struct packed {
		logic [63:0] resp_low;
		logic [63:0] resp_high;
	} resp_t;

	// Output beat: the decoded fields.
	typedef struct packed {
		logic [1:0]  structure;
		logic [26:0] access_time_ns;
		logic [14:0] access_time_clocks;
		logic [29:0] max_rate;
		logic [11:0] command_classes;
		logic [21:0] device_size;
		logic [2:0]  size_multiplier;
		logic [32:0] capacity_blocks;
		logic [7:0]  block_length_bits;
		logic [13:0] erase_blocks;
		logic [1:0]  protect_bits;
		logic [7:0]  attribute_bits;
	} decoded_t;

	// Raw CSD fields, sliced out of the response.
	typedef struct packed {
		logic [1:0]  structure;
		logic [3:0]  time_mant_code;
		logic [2:0]  time_exp_code;
		logic [7:0]  nsac;
		logic [3:0]  rate_mant_code;
		logic [2:0]  rate_exp_code;
		logic [11:0] ccc;
		logic [3:0]  rbb;
		logic [11:0] c_size_v1;
		logic [2:0]  size_mult_code;
		logic [21:0] c_size_v2;
		logic        erase_en;
		logic [6:0]  sector_size;
		logic [3:0]  wbb;
		logic [1:0]  protect;
		logic [7:0]  attr;
	} fields_t;

	// Looked-up factors and shift amounts ready for the arithmetic stage.
	typedef struct packed {
		logic [1:0]  structure;
		logic [23:0] time_scale;
		logic [6:0]  time_mant;
		logic [3:0]  time_small;
		logic [7:0]  nsac;
		logic [23:0] rate_scale;
		logic [6:0]  rate_mant;
		logic [11:0] ccc;
		logic [21:0] device_size;
		logic [2:0]  size_mult;
		logic [22:0] cap_base;
		logic [4:0]  cap_shift;
		logic [7:0]  block_len;
		logic [7:0]  erase_base;
		logic [2:0]  erase_shift;
		logic [1:0]  protect;
		logic [7:0]  attr;
	} terms_t;

	// Mantissa table shared by TAAC and TRAN_SPEED.
	function automatic logic [6:0] mant_value(input logic [3:0] code);
		logic [6:0] v;
		begin
			unique case (code)
				4'd0:    v = 7'd0;
				4'd1:    v = 7'd10;
				4'd2:    v = 7'd12;
				4'd3:    v = 7'd13;
				4'd4:    v = 7'd15;
				4'd5:    v = 7'd20;
				4'd6:    v = 7'd25;
				4'd7:    v = 7'd30;
				4'd8:    v = 7'd35;
				4'd9:    v = 7'd40;
				4'd10:   v = 7'd45;
				4'd11:   v = 7'd50;
				4'd12:   v = 7'd55;
				4'd13:   v = 7'd60;
				4'd14:   v = 7'd70;
				default: v = 7'd80;
			endcase
			return v;
		end
	endfunction

	// Mantissa divided by ten, rounded up; used when the time unit is 1 ns.
	function automatic logic [3:0] mant_ceil_div10(input logic [3:0] code);
		logic [3:0] v;
		begin
			unique case (code)
				4'd0:    v = 4'd0;
				4'd1:    v = 4'd1;
				4'd2:    v = 4'd2;
				4'd3:    v = 4'd2;
				4'd4:    v = 4'd2;
				4'd5:    v = 4'd2;
				4'd6:    v = 4'd3;
				4'd7:    v = 4'd3;
				4'd8:    v = 4'd4;
				4'd9:    v = 4'd4;
				4'd10:   v = 4'd5;
				4'd11:   v = 4'd5;
				4'd12:   v = 4'd6;
				4'd13:   v = 4'd6;
				4'd14:   v = 4'd7;
				default: v = 4'd8;
			endcase
			return v;
		end
	endfunction

	// Time unit divided by ten; the 1 ns unit is handled by the rounded table.
	function automatic logic [23:0] time_scale_div10(input logic [2:0] code);
		logic [23:0] v;
		begin
			unique case (code)
				3'd0:    v = 24'd0;
				3'd1:    v = 24'd1;
				3'd2:    v = 24'd10;
				3'd3:    v = 24'd100;
				3'd4:    v = 24'd1000;
				3'd5:    v = 24'd10000;
				3'd6:    v = 24'd100000;
				default: v = 24'd1000000;
			endcase
			return v;
		end
	endfunction

	// Transfer rate unit; reserved codes give zero.
	function automatic logic [23:0] rate_scale(input logic [2:0] code);
		logic [23:0] v;
		begin
			unique case (code)
				3'd0:    v = 24'd10000;
				3'd1:    v = 24'd100000;
				3'd2:    v = 24'd1000000;
				3'd3:    v = 24'd10000000;
				default: v = 24'd0;
			endcase
			return v;
		end
	endfunction

endpackage

[rtl/sdcsd_extract.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD CSD field extraction stage
// Slices the raw response into CSD fields and registers them (stage 1).
// ----------------------------------------------------------------------------
module sdcsd_extract (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid,
	input  sdcsd_pkg::resp_t     resp,
	output logic                 valid_s1,
	output sdcsd_pkg::fields_t   fields_s1
);
	import sdcsd_pkg::*;

	logic [127:0] raw;
	fields_t      fields;

	// CSD bit n sits at raw bit n - 8.
	assign raw = {resp.resp_high, resp.resp_low};

	// Field slicing.
	always_comb begin
		fields.structure      = raw[119:118];
		fields.time_mant_code = raw[110:107];
		fields.time_exp_code  = raw[106:104];
		fields.nsac           = raw[103:96];
		fields.rate_mant_code = raw[94:91];
		fields.rate_exp_code  = raw[90:88];
		fields.ccc            = raw[87:76];
		fields.rbb            = raw[75:72];
		fields.c_size_v1      = raw[65:54];
		fields.size_mult_code = raw[41:39];
		fields.c_size_v2      = raw[61:40];
		fields.erase_en       = raw[38];
		fields.sector_size    = raw[37:31];
		fields.wbb            = raw[17:14];
		fields.protect        = raw[5:4];
		fields.attr           = {raw[20:18], raw[13], raw[68], raw[69], raw[70], raw[71]};
	end

	// Stage 1 valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		fields_s1 <= fields;
	end

endmodule

[rtl/sdcsd_lookup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD CSD table lookup stage
// Resolves table codes and shift amounts per structure version (stage 2).
// ----------------------------------------------------------------------------
module sdcsd_lookup (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s1,
	input  sdcsd_pkg::fields_t   fields_s1,
	output logic                 valid_s2,
	output sdcsd_pkg::terms_t    terms_s2
);
	import sdcsd_pkg::*;

	terms_t     terms;
	logic [4:0] block_shift;
	logic       time_unit_ns;

	// Extra capacity shift for read blocks longer than 512 bytes.
	assign block_shift  = (fields_s1.rbb > 4'd9) ? ({1'b0, fields_s1.rbb} - 5'd9) : 5'd0;
	assign time_unit_ns = (fields_s1.time_exp_code == 3'd0);

	// Per-version selection; unknown structures leave everything but structure zero.
	always_comb begin
		terms           = '0;
		terms.structure = fields_s1.structure;
		unique case (fields_s1.structure)
			STRUCT_V1: begin
				terms.time_scale  = time_scale_div10(fields_s1.time_exp_code);
				terms.time_mant   = mant_value(fields_s1.time_mant_code);
				terms.time_small  = time_unit_ns ?
					mant_ceil_div10(fields_s1.time_mant_code) : 4'd0;
				terms.nsac        = fields_s1.nsac;
				terms.rate_scale  = rate_scale(fields_s1.rate_exp_code);
				terms.rate_mant   = mant_value(fields_s1.rate_mant_code);
				terms.ccc         = fields_s1.ccc;
				terms.device_size = {10'd0, fields_s1.c_size_v1};
				terms.size_mult   = fields_s1.size_mult_code;
				terms.cap_base    = {11'd0, fields_s1.c_size_v1} + 23'd1;
				terms.cap_shift   = {2'd0, fields_s1.size_mult_code} + 5'd2 + block_shift;
				terms.block_len   = {fields_s1.rbb, fields_s1.wbb};
				if (fields_s1.erase_en) begin
					terms.erase_base  = 8'd1;
					terms.erase_shift = 3'd0;
				end else if (fields_s1.wbb >= 4'd9) begin
					terms.erase_base  = {1'b0, fields_s1.sector_size} + 8'd1;
					terms.erase_shift = 3'(fields_s1.wbb - 4'd9);
				end
				terms.protect     = fields_s1.protect;
				terms.attr        = fields_s1.attr;
			end
			STRUCT_V2: begin
				terms.rate_scale  = rate_scale(fields_s1.rate_exp_code);
				terms.rate_mant   = mant_value(fields_s1.rate_mant_code);
				terms.ccc         = fields_s1.ccc;
				terms.device_size = fields_s1.c_size_v2;
				terms.cap_base    = {1'b0, fields_s1.c_size_v2} + 23'd1;
				terms.cap_shift   = V2_CAP_SHIFT;
				terms.block_len   = V2_BLOCK_LEN;
				terms.erase_base  = 8'd1;
				terms.protect     = fields_s1.protect;
				terms.attr        = V2_ATTR;
			end
			default: begin
				terms.structure = fields_s1.structure;
			end
		endcase
	end

	// Stage 2 valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		terms_s2 <= terms;
	end

endmodule

[rtl/sdcsd_compute.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD CSD arithmetic stage
// Forms products and shifted sizes and registers the decoded beat (stage 3).
// ----------------------------------------------------------------------------
module sdcsd_compute (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 valid_s2,
	input  sdcsd_pkg::terms_t    terms_s2,
	output logic                 valid_s3,
	output sdcsd_pkg::decoded_t  decoded_s3
);
	import sdcsd_pkg::*;

	logic [30:0] time_prod;
	logic [30:0] rate_prod;
	logic [14:0] clocks_prod;
	logic [32:0] capacity;
	logic [13:0] erase;
	decoded_t    decoded;

	// Two narrow multipliers and one constant scale.
	assign time_prod   = {7'd0, terms_s2.time_scale} * {24'd0, terms_s2.time_mant};
	assign rate_prod   = {7'd0, terms_s2.rate_scale} * {24'd0, terms_s2.rate_mant};
	assign clocks_prod = {7'd0, terms_s2.nsac} * 15'd100;

	// Capacity and erase size are plain left shifts.
	assign capacity = {10'd0, terms_s2.cap_base} << terms_s2.cap_shift;
	assign erase    = {6'd0, terms_s2.erase_base} << terms_s2.erase_shift;

	// Result assembly.
	always_comb begin
		decoded.structure          = terms_s2.structure;
		decoded.access_time_ns     = time_prod[26:0] + {23'd0, terms_s2.time_small};
		decoded.access_time_clocks = clocks_prod;
		decoded.max_rate           = rate_prod[29:0];
		decoded.command_classes    = terms_s2.ccc;
		decoded.device_size        = terms_s2.device_size;
		decoded.size_multiplier    = terms_s2.size_mult;
		decoded.capacity_blocks    = capacity;
		decoded.block_length_bits  = terms_s2.block_len;
		decoded.erase_blocks       = erase;
		decoded.protect_bits       = terms_s2.protect;
		decoded.attribute_bits     = terms_s2.attr;
	end

	// Stage 3 valid bit, which is the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	// Stage 3 payload, held on the result port.
	always_ff @(posedge clk) begin
		decoded_s3 <= decoded;
	end

endmodule

[rtl/sd_csd_register_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD CSD register decoder
// Decodes one 128-bit CSD response (CRC byte stripped) into its fields.
// ----------------------------------------------------------------------------
//  Channel   Signals               Beat taken when
//  --------  --------------------  ---------------------------------
//  request   start, busy, resp     start high and busy low at clk rise
//  result    done, decoded         done high at clk rise
//
// Each beat passes three register stages (slice, table lookup, multiply and
// shift). Its valid bit moves through valid_s1 and valid_s2 to done, the stage
// 3 valid bit, which marks the result beat.
// A new beat may be taken every cycle; busy is always low.
// arst_n clears the stage valid bits at once; payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
module sd_csd_register_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  sdcsd_pkg::resp_t     resp,
	output logic                 done,
	output sdcsd_pkg::decoded_t  decoded
);
	import sdcsd_pkg::*;

	logic    accept;
	logic    valid_s1;
	logic    valid_s2;
	fields_t fields_s1;
	terms_t  terms_s2;

	// The pipeline moves every cycle, so a beat is always taken.
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	sdcsd_extract u_extract (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (accept),
		.resp      (resp),
		.valid_s1  (valid_s1),
		.fields_s1 (fields_s1)
	);

	sdcsd_lookup u_lookup (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.fields_s1 (fields_s1),
		.valid_s2  (valid_s2),
		.terms_s2  (terms_s2)
	);

	sdcsd_compute u_compute (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.terms_s2   (terms_s2),
		.valid_s3   (done),
		.decoded_s3 (decoded)
	);

endmodule

[sim/tb_sd_csd_register_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD CSD register decoder testbench
// Feeds raw CSD responses to the decoder and checks every decoded field
// against a local model of the CSD layout and its lookup tables. A short
// directed set covers the table extremes, both known structures, the unknown
// structures and the small-block and erase corner cases. Random responses
// follow, sent in bursts with random gaps.
// ----------------------------------------------------------------------------
module tb_sd_csd_register_decoder;
	import sdcsd_pkg::*;

	localparam int RANDOM_BEATS = 1750;
	localparam int TAIL_CYCLES  = 12;
	localparam int MAX_REPORTS  = 10;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	resp_t    resp = '0;
	logic     done;
	decoded_t decoded;

	resp_t    csd_words_q[$];
	decoded_t decoded_q[$];
	logic     resp_taken = 1'b0;
	int       error_count = 0;
	int       burst_left = 1;
	int       idle_left = 0;

	sd_csd_register_decoder i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.resp    (resp),
		.done    (done),
		.decoded (decoded)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Safety net against a hung pipeline.
	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Reads a CSD field of the given width whose lowest bit is CSD bit n.
	// CSD bit n lives at raw bit (n - 8) mod 128.
	function automatic logic [31:0] csd_get(input logic [127:0] raw, input int unsigned n,
			input int unsigned size);
		logic [31:0] v;
		v = '0;
		for (int unsigned i = 0; i < size; i++)
			v[i] = raw[(n - 8 + i) & 127];
		return v;
	endfunction

	function automatic logic [127:0] csd_put(input logic [127:0] raw, input int unsigned n,
			input int unsigned size, input logic [31:0] val);
		logic [127:0] r;
		r = raw;
		for (int unsigned i = 0; i < size; i++)
			r[(n - 8 + i) & 127] = val[i];
		return r;
	endfunction

	// Mantissa shared by TAAC and TRAN_SPEED, scaled by ten.
	function automatic longint unsigned mant_x10(input logic [3:0] code);
		case (code)
			4'd0:    return 0;
			4'd1:    return 10;
			4'd2:    return 12;
			4'd3:    return 13;
			4'd4:    return 15;
			4'd5:    return 20;
			4'd6:    return 25;
			4'd7:    return 30;
			4'd8:    return 35;
			4'd9:    return 40;
			4'd10:   return 45;
			4'd11:   return 50;
			4'd12:   return 55;
			4'd13:   return 60;
			4'd14:   return 70;
			default: return 80;
		endcase
	endfunction

	// TAAC unit in nanoseconds.
	function automatic longint unsigned taac_unit(input logic [2:0] code);
		longint unsigned u;
		u = 1;
		for (int i = 0; i < code; i++)
			u = u * 10;
		return u;
	endfunction

	// TRAN_SPEED unit in bits per second, divided by ten; codes 4 and up are reserved.
	function automatic longint unsigned tran_unit(input logic [2:0] code);
		longint unsigned u;
		if (code > 3'd3)
			return 0;
		u = 10000;
		for (int i = 0; i < code; i++)
			u = u * 10;
		return u;
	endfunction

	// Decodes one raw response the way the block is meant to.
	function automatic decoded_t decode_csd(input resp_t r);
		logic [127:0]    raw;
		decoded_t        d;
		logic [1:0]      st;
		logic [3:0]      rbb;
		logic [3:0]      wbb;
		longint unsigned v;
		raw = {r.resp_high, r.resp_low};
		d = '0;
		st = 2'(csd_get(raw, 126, 2));
		d.structure = st;
		if (st == STRUCT_V1) begin
			v = (taac_unit(3'(csd_get(raw, 112, 3))) * mant_x10(4'(csd_get(raw, 115, 4)))
				+ 9) / 10;
			d.access_time_ns = 27'(v);
			v = longint'(csd_get(raw, 104, 8)) * 100;
			d.access_time_clocks = 15'(v);
			v = tran_unit(3'(csd_get(raw, 96, 3))) * mant_x10(4'(csd_get(raw, 99, 4)));
			d.max_rate = 30'(v);
			d.command_classes = 12'(csd_get(raw, 84, 12));
			d.device_size = 22'(csd_get(raw, 62, 12));
			d.size_multiplier = 3'(csd_get(raw, 47, 3));
			rbb = 4'(csd_get(raw, 80, 4));
			wbb = 4'(csd_get(raw, 22, 4));
			v = (longint'(csd_get(raw, 62, 12)) + 1) << (d.size_multiplier + 2);
			// Block lengths below 512 bytes leave the capacity unshifted.
			if (rbb > 4'd9)
				v = v << (rbb - 4'd9);
			d.capacity_blocks = 33'(v);
			d.block_length_bits = {rbb, wbb};
			if (csd_get(raw, 46, 1) != 0) begin
				d.erase_blocks = 14'd1;
			end else if (wbb >= 4'd9) begin
				v = (longint'(csd_get(raw, 39, 7)) + 1) << (wbb - 4'd9);
				d.erase_blocks = 14'(v);
			end
			d.protect_bits = 2'(csd_get(raw, 12, 2));
			d.attribute_bits = {3'(csd_get(raw, 26, 3)), 1'(csd_get(raw, 21, 1)),
				1'(csd_get(raw, 76, 1)), 1'(csd_get(raw, 77, 1)),
				1'(csd_get(raw, 78, 1)), 1'(csd_get(raw, 79, 1))};
		end else if (st == STRUCT_V2) begin
			v = tran_unit(3'(csd_get(raw, 96, 3))) * mant_x10(4'(csd_get(raw, 99, 4)));
			d.max_rate = 30'(v);
			d.command_classes = 12'(csd_get(raw, 84, 12));
			d.device_size = 22'(csd_get(raw, 48, 22));
			v = (longint'(csd_get(raw, 48, 22)) + 1) << V2_CAP_SHIFT;
			d.capacity_blocks = 33'(v);
			d.block_length_bits = V2_BLOCK_LEN;
			d.erase_blocks = 14'd1;
			d.protect_bits = 2'(csd_get(raw, 12, 2));
			d.attribute_bits = V2_ATTR;
		end
		return d;
	endfunction

	task automatic compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			error_count++;
			if (error_count <= MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
		end
	endtask

	task automatic queue_csd(input logic [127:0] raw);
		resp_t r;
		r.resp_low = raw[63:0];
		r.resp_high = raw[127:64];
		csd_words_q.push_back(r);
	endtask

	function automatic logic [127:0] random_raw();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Result check and expectation capture, both on the rising edge.
	always @(posedge clk) begin : monitor
		decoded_t want;
		resp_taken <= arst_n && start && !busy;
		if (arst_n) begin
			if (done) begin
				if (decoded_q.size() == 0) begin
					error_count++;
					if (error_count <= MAX_REPORTS)
						$display("%0t: result beat with nothing expected", $realtime);
				end else begin
					want = decoded_q.pop_front();
					compare_field("structure", 64'(want.structure),
						64'(decoded.structure));
					compare_field("access_time_ns", 64'(want.access_time_ns),
						64'(decoded.access_time_ns));
					compare_field("access_time_clocks", 64'(want.access_time_clocks),
						64'(decoded.access_time_clocks));
					compare_field("max_rate", 64'(want.max_rate), 64'(decoded.max_rate));
					compare_field("command_classes", 64'(want.command_classes),
						64'(decoded.command_classes));
					compare_field("device_size", 64'(want.device_size),
						64'(decoded.device_size));
					compare_field("size_multiplier", 64'(want.size_multiplier),
						64'(decoded.size_multiplier));
					compare_field("capacity_blocks", 64'(want.capacity_blocks),
						64'(decoded.capacity_blocks));
					compare_field("block_length_bits", 64'(want.block_length_bits),
						64'(decoded.block_length_bits));
					compare_field("erase_blocks", 64'(want.erase_blocks),
						64'(decoded.erase_blocks));
					compare_field("protect_bits", 64'(want.protect_bits),
						64'(decoded.protect_bits));
					compare_field("attribute_bits", 64'(want.attribute_bits),
						64'(decoded.attribute_bits));
				end
			end
			if (start && !busy)
				decoded_q.push_back(decode_csd(resp));
		end
	end

	// Request driver: bursts of beats separated by random idle gaps.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (resp_taken)
				csd_words_q.delete(0);
			if (!(start && !resp_taken)) begin
				if (idle_left > 0) begin
					start <= 1'b0;
					idle_left--;
				end else if (csd_words_q.size() > 0) begin
					start <= 1'b1;
					resp <= csd_words_q[0];
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	initial begin
		logic [127:0] raw;
		int unsigned  sel;

		// All zero: structure 0 with every field at its minimum.
		queue_csd('0);
		// All ones: an unknown structure, everything else zero.
		queue_csd('1);
		// Structure 0 at its maxima, erase enable set.
		queue_csd(csd_put('1, 126, 2, 32'(STRUCT_V1)));
		// Structure 0 at its maxima with erase enable clear: largest erase unit.
		queue_csd(csd_put(csd_put('1, 126, 2, 32'(STRUCT_V1)), 46, 1, 0));
		// Read block below 512 bytes, largest c_size and multiplier.
		raw = csd_put(csd_put('0, 80, 4, 8), 62, 12, 32'hfff);
		queue_csd(csd_put(raw, 47, 3, 7));
		// Erase undefined: enable clear and write block below 512 bytes.
		raw = csd_put(csd_put(random_raw(), 126, 2, 32'(STRUCT_V1)), 46, 1, 0);
		queue_csd(csd_put(raw, 22, 4, 8));
		// Read and write block exactly 512 bytes, erase enable clear.
		raw = csd_put(csd_put(random_raw(), 126, 2, 32'(STRUCT_V1)), 46, 1, 0);
		queue_csd(csd_put(csd_put(raw, 22, 4, 9), 80, 4, 9));
		// Read block of 1024 bytes.
		queue_csd(csd_put(csd_put(random_raw(), 126, 2, 32'(STRUCT_V1)), 80, 4, 10));
		// Version 2 with the largest c_size, and with all zero content.
		queue_csd(csd_put('1, 126, 2, 32'(STRUCT_V2)));
		queue_csd(csd_put('0, 126, 2, 32'(STRUCT_V2)));
		// Unknown structures with random content.
		queue_csd(csd_put(random_raw(), 126, 2, 32'(STRUCT_RSVD2)));
		queue_csd(csd_put(random_raw(), 126, 2, 32'(STRUCT_RSVD3)));
		// Walk the rate units, time units 0 and 4 to 7, odd time and even rate mantissa codes, and the 1 ns rounding.
		for (int k = 0; k < 8; k++) begin
			raw = csd_put(random_raw(), 126, 2, 32'(STRUCT_V1));
			raw = csd_put(csd_put(raw, 112, 3, (k < 4) ? 0 : k), 115, 4, 2 * k + 1);
			raw = csd_put(csd_put(raw, 96, 3, k), 99, 4, 14 - 2 * k);
			queue_csd(raw);
		end

		// Random part: mostly the two known structures.
		for (int n = 0; n < RANDOM_BEATS; n++) begin
			raw = random_raw();
			sel = $urandom_range(0, 9);
			if (sel < 5)
				raw = csd_put(raw, 126, 2, 32'(STRUCT_V1));
			else if (sel < 8)
				raw = csd_put(raw, 126, 2, 32'(STRUCT_V2));
			queue_csd(raw);
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (csd_words_q.size() != 0 || decoded_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (error_count == 0 && decoded_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
rtl/sdcsd_pkg.sv
rtl/sdcsd_extract.sv
rtl/sdcsd_lookup.sv
rtl/sdcsd_compute.sv
rtl/sd_csd_register_decoder.sv
sim/tb_sd_csd_register_decoder.sv
